// File: rtl/core/csim_pkg.sv
// ----------------------------------------------------------------------------
// csim_pkg
// Shared types and constants of the cosine similarity engine: payload
// structs, accumulator widths and the hand-off record between front and back.
// ----------------------------------------------------------------------------
package csim_pkg;

  // Vector geometry
  localparam int MAX_DIM  = 1024;
  localparam int ELEM_W   = 16;
  localparam int CNT_W    = $clog2(MAX_DIM + 1);
  localparam int LOG_DIM  = $clog2(MAX_DIM);

  // Products and accumulators
  localparam int PROD_W   = 2 * ELEM_W;            // signed element product
  localparam int EPROD_W  = 2 * ELEM_W - 1;        // square of one element
  localparam int DOT_W    = PROD_W + LOG_DIM;      // signed dot accumulator
  localparam int EN_W     = EPROD_W + LOG_DIM;     // energy accumulator

  // Result format and back-end widths
  localparam int SIM_W    = 16;                    // Q1.15
  localparam int SIM_MAX  = 2 ** (SIM_W - 1) - 1;
  localparam int Q_W      = SIM_W;                 // bits of the root search
  localparam int K_W      = $clog2(Q_W);
  localparam int P_W      = 2 * EN_W;              // energy product
  localparam int ROOT_W   = P_W + 2 * Q_W;         // compare width of the search
  localparam int MUL_STEPS = EN_W;                 // shift-add multiplier steps
  localparam int MC_W     = $clog2(MUL_STEPS);

  // Hand-off queue, depth must be a power of two
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [ELEM_W-1:0] ref_element;
    logic signed [ELEM_W-1:0] curr_element;
    logic                     last_element;
  } csim_in_t;

  typedef struct packed {
    logic signed [SIM_W-1:0] similarity;
    logic                    zero_norm;
    logic                    length_overflow;
  } csim_out_t;

  // Finished sums of one vector pair
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [EN_W-1:0]         ref_en;
    logic [EN_W-1:0]         curr_en;
    logic                    ovf;
  } csim_job_t;

endpackage

// File: rtl/core/csim_front.sv
// ----------------------------------------------------------------------------
// csim_front
// Input side: takes element pairs, squares and multiplies them, accumulates
// dot product and energies, and on the last pair hands the sums to the queue.
// ----------------------------------------------------------------------------
module csim_front import csim_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csim_in_t          in_data,
  input  logic [QCNT_W-1:0] q_count,
  output logic              q_push,
  output csim_job_t         q_job
);

  logic [CNT_W-1:0]         cnt_r;
  logic                     ovf_r;
  logic                     s1_vld_r;
  logic                     s1_acc_r;
  logic                     s1_last_r;
  logic                     s1_ovf_r;
  logic signed [PROD_W-1:0] s1_dot_r;
  logic [EPROD_W-1:0]       s1_ren_r;
  logic [EPROD_W-1:0]       s1_cen_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic [EN_W-1:0]          ren_r;
  logic [EN_W-1:0]          cen_r;

  logic                     fire;
  logic                     dim_full;
  logic                     pend;
  logic [QCNT_W:0]          used;
  logic signed [PROD_W-1:0] prod_dot;
  logic signed [PROD_W-1:0] prod_ren;
  logic signed [PROD_W-1:0] prod_cen;
  logic signed [DOT_W-1:0]  dot_nxt;
  logic [EN_W-1:0]          ren_nxt;
  logic [EN_W-1:0]          cen_nxt;

  // Queue slots are reserved for a last pair still in the pipeline
  assign pend     = s1_vld_r && s1_last_r;
  assign used     = {1'b0, q_count} + {{QCNT_W{1'b0}}, pend};
  assign in_ready = used < (QCNT_W + 1)'(QDEPTH);
  assign fire     = in_valid && in_ready;
  assign dim_full = (cnt_r == CNT_W'(MAX_DIM));

  // Element products
  assign prod_dot = in_data.ref_element * in_data.curr_element;
  assign prod_ren = in_data.ref_element * in_data.ref_element;
  assign prod_cen = in_data.curr_element * in_data.curr_element;

  // Running sums including the pair in stage one
  always_comb begin
    dot_nxt = dot_r;
    ren_nxt = ren_r;
    cen_nxt = cen_r;
    if (s1_acc_r) begin
      dot_nxt = dot_r + {{(DOT_W-PROD_W){s1_dot_r[PROD_W-1]}}, s1_dot_r};
      ren_nxt = ren_r + {{(EN_W-EPROD_W){1'b0}}, s1_ren_r};
      cen_nxt = cen_r + {{(EN_W-EPROD_W){1'b0}}, s1_cen_r};
    end
  end

  assign q_push        = pend;
  assign q_job.dot     = dot_nxt;
  assign q_job.ref_en  = ren_nxt;
  assign q_job.curr_en = cen_nxt;
  assign q_job.ovf     = s1_ovf_r;

  // Pair count and sticky overflow, stage one control, accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      s1_vld_r <= 1'b0;
      s1_acc_r <= 1'b0;
      dot_r    <= '0;
      ren_r    <= '0;
      cen_r    <= '0;
    end else begin
      s1_vld_r <= fire;
      s1_acc_r <= fire && !dim_full;
      if (fire) begin
        if (in_data.last_element) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else if (dim_full) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (s1_vld_r) begin
        if (s1_last_r) begin
          dot_r <= '0;
          ren_r <= '0;
          cen_r <= '0;
        end else begin
          dot_r <= dot_nxt;
          ren_r <= ren_nxt;
          cen_r <= cen_nxt;
        end
      end
    end
  end

  // Stage one payload
  always_ff @(posedge clk) begin
    if (fire) begin
      s1_last_r <= in_data.last_element;
      s1_ovf_r  <= ovf_r || dim_full;
      s1_dot_r  <= prod_dot;
      s1_ren_r  <= prod_ren[EPROD_W-1:0];
      s1_cen_r  <= prod_cen[EPROD_W-1:0];
    end
  end

endmodule

// File: rtl/core/csim_fifo.sv
// ----------------------------------------------------------------------------
// csim_fifo
// Short queue of finished vector sums between the front and the back end.
// ----------------------------------------------------------------------------
module csim_fifo import csim_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  csim_job_t         push_job,
  input  logic              pop,
  output csim_job_t         pop_job,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  csim_job_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign pop_job = mem_r[rd_ptr_r];
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

// File: rtl/core/csim_back.sv
// ----------------------------------------------------------------------------
// csim_back
// Result side: forms ref_en*curr_en and dot^2 on a shift-add multiplier,
// then finds the rounded ratio bit by bit and drives the output register.
// ----------------------------------------------------------------------------
module csim_back import csim_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  csim_job_t q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output csim_out_t out_data
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MULP = 3'd1;
  localparam logic [2:0] B_MULM = 3'd2;
  localparam logic [2:0] B_ROOT = 3'd3;
  localparam logic [2:0] B_RES  = 3'd4;

  logic [2:0]          state_r;
  logic [P_W-1:0]      mul_a_r;
  logic [EN_W-1:0]     mul_b_r;
  logic [P_W-1:0]      mul_acc_r;
  logic [MC_W-1:0]     mul_cnt_r;
  logic [P_W-1:0]      p_r;
  logic [ROOT_W-1:0]   m_r;
  logic [ROOT_W-1:0]   s_r;
  logic [ROOT_W-1:0]   u_r;
  logic [ROOT_W-1:0]   pk_r;
  logic [K_W-1:0]      k_r;
  logic [Q_W-1:0]      t_r;
  logic [EN_W-1:0]     mag_r;
  logic                neg_r;
  logic                zero_r;
  logic                ovf_r;
  logic                out_vld_r;
  csim_out_t           out_data_r;

  logic [P_W-1:0]      mul_acc_nxt;
  logic                mul_last;
  logic [ROOT_W-1:0]   trial;
  logic                root_ok;
  logic [Q_W:0]        q;
  logic [SIM_W-1:0]    sim;
  logic                out_free;
  logic signed [DOT_W-1:0] dot_abs;
  logic                job_zero;

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_vld_r || out_ready;
  assign q_pop     = (state_r == B_IDLE) && !q_empty;

  // Job decode
  assign dot_abs  = q_job.dot[DOT_W-1] ? -q_job.dot : q_job.dot;
  assign job_zero = (q_job.ref_en == '0) || (q_job.curr_en == '0);

  // Shift-add multiplier step
  assign mul_acc_nxt = mul_acc_r + (mul_b_r[0] ? mul_a_r : '0);
  assign mul_last    = (mul_cnt_r == MC_W'(MUL_STEPS - 1));

  // Root search step: try setting bit k of t, t^2*P against dot^2 scaled
  assign trial   = s_r + u_r + pk_r;
  assign root_ok = (trial <= m_r);

  // Largest t not above the root gives q = (t + 1) / 2, then sign and clamp
  assign q = ({1'b0, t_r} + (Q_W + 1)'(1)) >> 1;
  always_comb begin
    if (zero_r)
      sim = '0;
    else if (neg_r)
      sim = SIM_W'(0) - q[SIM_W-1:0];
    else if (q > (Q_W + 1)'(SIM_MAX))
      sim = SIM_W'(SIM_MAX);
    else
      sim = q[SIM_W-1:0];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      if ((state_r == B_RES) && out_free) out_vld_r <= 1'b1;
      else if (out_ready)                 out_vld_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_empty) state_r <= job_zero ? B_RES : B_MULP;
        end
        B_MULP: begin
          if (mul_last) state_r <= B_MULM;
        end
        B_MULM: begin
          if (mul_last) state_r <= B_ROOT;
        end
        B_ROOT: begin
          if (k_r == '0) state_r <= B_RES;
        end
        B_RES: begin
          if (out_free) state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        mag_r     <= dot_abs[EN_W-1:0];
        neg_r     <= q_job.dot[DOT_W-1];
        zero_r    <= job_zero;
        ovf_r     <= q_job.ovf;
        mul_a_r   <= P_W'(q_job.ref_en);
        mul_b_r   <= q_job.curr_en;
        mul_acc_r <= '0;
        mul_cnt_r <= '0;
      end
      B_MULP: begin
        if (mul_last) begin
          p_r       <= mul_acc_nxt;
          mul_a_r   <= P_W'(mag_r);
          mul_b_r   <= mag_r;
          mul_acc_r <= '0;
          mul_cnt_r <= '0;
        end else begin
          mul_a_r   <= mul_a_r << 1;
          mul_b_r   <= mul_b_r >> 1;
          mul_acc_r <= mul_acc_nxt;
          mul_cnt_r <= mul_cnt_r + 1'b1;
        end
      end
      B_MULM: begin
        if (mul_last) begin
          m_r  <= {mul_acc_nxt, {(2 * Q_W){1'b0}}};
          s_r  <= '0;
          u_r  <= '0;
          pk_r <= ROOT_W'(p_r) << (2 * (Q_W - 1));
          k_r  <= K_W'(Q_W - 1);
          t_r  <= '0;
        end else begin
          mul_a_r   <= mul_a_r << 1;
          mul_b_r   <= mul_b_r >> 1;
          mul_acc_r <= mul_acc_nxt;
          mul_cnt_r <= mul_cnt_r + 1'b1;
        end
      end
      B_ROOT: begin
        if (root_ok) s_r <= trial;
        u_r      <= (u_r >> 1) + (root_ok ? pk_r : '0);
        pk_r     <= pk_r >> 2;
        t_r[k_r] <= root_ok;
        k_r      <= k_r - 1'b1;
      end
      B_RES: begin
        if (out_free) begin
          out_data_r.similarity      <= sim;
          out_data_r.zero_norm       <= zero_r;
          out_data_r.length_overflow <= ovf_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/cosine_similarity_engine_core.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine_core
// Cosine similarity of two streamed feature vectors, result in Q1.15.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one element pair (Q8.8) per transaction; last_element closes the
//           vector pair. Pairs are taken at one per cycle while in_ready is high.
//   out_* : one transaction per vector pair: similarity, zero_norm and
//           length_overflow.
// Result path: from the last pair to out_valid through the front stage-one
//   register, the queue, the shift-add multiplier for ref*curr energy and
//   then for dot squared, the bitwise root search and the result state; a
//   zero-norm vector pair skips the multiplier and the root search.
// Throughput: one pair per cycle in the front while in_ready is high; the
//   back end works on one vector pair at a time on its single serial
//   multiplier. A two-entry queue of finished sums lets the front run ahead;
//   in_ready drops only when both entries are taken or reserved.
// Reset: clears accumulators, pair count, queue and output valid flag.
// Stall: while out_ready is low the result is held and the back end waits;
//   the front keeps accumulating until the queue fills.
// ----------------------------------------------------------------------------
module cosine_similarity_engine_core import csim_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  csim_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output csim_out_t out_data
);

  logic              q_push;
  csim_job_t         q_push_job;
  logic              q_pop;
  csim_job_t         q_pop_job;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;

  // Accumulating front
  csim_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_job    (q_push_job)
  );

  // Queue of finished sums
  csim_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .empty    (q_empty),
    .count    (q_count)
  );

  // Ratio and root back end
  csim_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/csim_checker.sv
// ----------------------------------------------------------------------------
// csim_checker
// Port-level checks of the cosine similarity engine, bound to the top level.
// ----------------------------------------------------------------------------
module csim_checker import csim_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input csim_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input csim_out_t out_data
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Zero norm forces a zero similarity
  a_zero_sim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_norm |-> out_data.similarity == '0)
    else $error("zero_norm with non-zero similarity");

  // Output register is empty after reset
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cosine_similarity_engine_core csim_checker u_csim_checker (.*);
